// File: design/rfe_pkg.sv
package rfe_pkg;

  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgCrcKey      = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStartMarker = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgEndMarker   = 2'd2;

  localparam logic [31:0] CrcPoly         = 32'hEDB8_8320;
  localparam logic [31:0] CrcInv          = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcKeyReset     = 32'h0000_0000;
  localparam logic [7:0]  StartMarkReset  = 8'h02;
  localparam logic [7:0]  EndMarkReset    = 8'h03;
  localparam logic [7:0]  HeaderPad       = 8'h00;
  localparam logic [9:0]  MaxPayload      = 10'd512;

  typedef struct packed {
    logic [31:0] crc_key;
    logic [7:0]  start_marker;
    logic [7:0]  end_marker;
  } rfe_cfg_t;

  // One classified item: which frame sections it emits and their contents.
  typedef struct packed {
    logic        hdr;
    logic        data;
    logic        trl;
    logic [7:0]  msg_type;
    logic [9:0]  len;
    logic [7:0]  data_byte;
    logic [31:0] crc;
  } rfe_cmd_t;

  // Reflected CRC-32 update over one byte, bit by bit.
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: design/rfe_if.sv
interface rfe_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_type;
  logic [9:0] payload_len;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;
  logic       empty_msg;

  modport source (output valid, msg_type, payload_len, data_byte, first_byte, last_byte,
                  empty_msg, input ready);
  modport sink (input valid, msg_type, payload_len, data_byte, first_byte, last_byte,
                empty_msg, output ready);
endinterface

interface rfe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;

  modport source (output valid, out_byte, run_end, input ready);
  modport sink (input valid, out_byte, run_end, output ready);
endinterface

// File: design/reply_frame_encoder_crc32_unit.sv
// An accepted item enters the command queue; its bytes leave through the output register.
// Throughput: one frame byte per cycle while the receiver is ready; an item emits 1 to 11
// bytes (header 5, payload 1, trailer 5), so plain payload bytes stream at one item per cycle.
// The command queue between the classifier and the byte sequencer absorbs header/trailer bursts.
// Reset (rst_ni, asynchronous, active low) empties the queue and the output register and
// restores crc_key 0, start marker 0x02, end marker 0x03 and the running CRC 0xFFFFFFFF.
module reply_frame_encoder_crc32_unit
  import rfe_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  rfe_item_if.sink           item_i,
  rfe_byte_if.source         frame_o
);

  rfe_cfg_t cfg_q, cfg_d;
  rfe_cmd_t push_cmd;
  rfe_cmd_t head_cmd;
  logic     push;
  logic     q_full;
  logic     head_valid;
  logic     pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCrcKey:      cfg_d.crc_key      = cfg_data_i;
        CfgStartMarker: cfg_d.start_marker = cfg_data_i[7:0];
        CfgEndMarker:   cfg_d.end_marker   = cfg_data_i[7:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crc_key      <= CrcKeyReset;
      cfg_q.start_marker <= StartMarkReset;
      cfg_q.end_marker   <= EndMarkReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rfe_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .item_i   (item_i),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  rfe_queue #(
    .Depth (FIFO_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (push_cmd),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_cmd)
  );

  rfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .frame_o      (frame_o)
  );

endmodule

// File: design/rfe_front.sv
module rfe_front
  import rfe_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rfe_cfg_t       cfg_i,
  rfe_item_if.sink       item_i,
  input  logic           q_full_i,
  output logic           push_o,
  output rfe_cmd_t       cmd_o
);

  logic [31:0] crc_q, crc_d;
  logic [31:0] crc_base;
  logic [31:0] crc_next;
  logic [31:0] key_inv;
  logic        accept;
  logic        closes;

  assign item_i.ready = !q_full_i;
  assign accept       = item_i.valid && !q_full_i;
  assign push_o       = accept;

  assign key_inv  = cfg_i.crc_key ^ CrcInv;
  assign crc_base = item_i.first_byte ? key_inv : crc_q;
  assign crc_next = crc_byte(crc_base, item_i.data_byte);
  assign closes   = item_i.empty_msg || item_i.last_byte;

  always_comb begin
    cmd_o.hdr       = item_i.empty_msg || item_i.first_byte;
    cmd_o.data      = !item_i.empty_msg;
    cmd_o.trl       = closes;
    cmd_o.msg_type  = item_i.msg_type;
    cmd_o.len       = (item_i.payload_len > MaxPayload) ? MaxPayload : item_i.payload_len;
    cmd_o.data_byte = item_i.data_byte;
    // The CRC of an empty payload is the key itself.
    cmd_o.crc       = item_i.empty_msg ? cfg_i.crc_key : (crc_next ^ CrcInv);
  end

  always_comb begin
    crc_d = crc_q;
    if (accept) begin
      crc_d = closes ? key_inv : crc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcKeyReset ^ CrcInv;
    end else begin
      crc_q <= crc_d;
    end
  end

endmodule

// File: design/rfe_queue.sv
module rfe_queue
  import rfe_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  rfe_cmd_t cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     head_valid_o,
  output rfe_cmd_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rfe_cmd_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: design/rfe_back.sv
module rfe_back
  import rfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  rfe_cfg_t   cfg_i,
  input  logic       head_valid_i,
  input  rfe_cmd_t   head_i,
  output logic       pop_o,
  rfe_byte_if.source frame_o
);

  typedef enum logic [3:0] {
    PosStart, PosType, PosPad, PosLenLo, PosLenHi, PosData,
    PosCrc0, PosCrc1, PosCrc2, PosCrc3, PosEnd
  } pos_e;

  pos_e       step_q, step_d;
  pos_e       cur_pos;
  pos_e       first_pos;
  pos_e       last_pos;
  pos_e       next_pos;
  logic       busy_q, busy_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       run_end_q, run_end_d;
  logic       emit;
  logic       at_last;
  logic [7:0] sel_byte;

  assign first_pos = head_i.hdr ? PosStart : (head_i.data ? PosData : PosCrc0);
  assign last_pos  = head_i.trl ? PosEnd : PosData;
  assign cur_pos   = busy_q ? step_q : first_pos;
  assign at_last   = (cur_pos == last_pos);
  assign emit      = head_valid_i && (!out_valid_q || frame_o.ready);
  assign pop_o     = emit && at_last;

  always_comb begin
    case (cur_pos)
      PosLenHi: next_pos = head_i.data ? PosData : PosCrc0;
      PosStart: next_pos = PosType;
      PosType:  next_pos = PosPad;
      PosPad:   next_pos = PosLenLo;
      PosLenLo: next_pos = PosLenHi;
      PosData:  next_pos = PosCrc0;
      PosCrc0:  next_pos = PosCrc1;
      PosCrc1:  next_pos = PosCrc2;
      PosCrc2:  next_pos = PosCrc3;
      PosCrc3:  next_pos = PosEnd;
      default:  next_pos = PosEnd;
    endcase
  end

  always_comb begin
    case (cur_pos)
      PosStart: sel_byte = cfg_i.start_marker;
      PosType:  sel_byte = head_i.msg_type;
      PosPad:   sel_byte = HeaderPad;
      PosLenLo: sel_byte = head_i.len[7:0];
      PosLenHi: sel_byte = {6'b0, head_i.len[9:8]};
      PosData:  sel_byte = head_i.data_byte;
      PosCrc0:  sel_byte = head_i.crc[7:0];
      PosCrc1:  sel_byte = head_i.crc[15:8];
      PosCrc2:  sel_byte = head_i.crc[23:16];
      PosCrc3:  sel_byte = head_i.crc[31:24];
      PosEnd:   sel_byte = cfg_i.end_marker;
      default:  sel_byte = cfg_i.end_marker;
    endcase
  end

  always_comb begin
    step_d      = step_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    run_end_d   = run_end_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = sel_byte;
      run_end_d   = at_last;
      busy_d      = !at_last;
      step_d      = next_pos;
    end else if (frame_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= PosStart;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      run_end_q   <= 1'b0;
    end else begin
      step_q      <= step_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      out_byte_q  <= out_byte_d;
      run_end_q   <= run_end_d;
    end
  end

  assign frame_o.valid    = out_valid_q;
  assign frame_o.out_byte = out_byte_q;
  assign frame_o.run_end  = run_end_q;

endmodule

// File: design/rfe_checker.sv
module rfe_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_run_end_i
);

  logic [15:0] pending_q;
  logic        in_fire;
  logic        out_done;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_done = out_valid_i && out_ready_i && out_run_end_i;

  // Items accepted whose last byte has not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + {15'b0, in_fire} - {15'b0, out_done};
    end
  end

  a_no_spurious_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pending_q != '0))
    else $error("output byte shown with no item outstanding");

  a_frame_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !out_run_end_i) |=> out_valid_i)
    else $error("bytes of one item are not back to back");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("output valid dropped while stalled");

endmodule

bind reply_frame_encoder_crc32_unit rfe_checker u_rfe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (item_i.valid),
  .in_ready_i    (item_i.ready),
  .out_valid_i   (frame_o.valid),
  .out_ready_i   (frame_o.ready),
  .out_run_end_i (frame_o.run_end)
);

// File: dv/tb.sv
module tb;
  import rfe_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  // Index 3 decodes to no register; writes to it must be dropped.
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  typedef struct packed {
    logic [7:0] msg_type;
    logic [9:0] len;
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       empty;
  } frame_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic       run_end;
  } frame_byte_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [31:0]        cfg_data_i;

  rfe_item_if item_if ();
  rfe_byte_if frame_if ();

  reply_frame_encoder_crc32_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_if),
    .frame_o    (frame_if)
  );

  frame_item_t pending_items_q[$];
  frame_byte_t frame_bytes_q[$];

  // Shadow of the block's registers and running CRC.
  logic [31:0] key_shadow;
  logic [7:0]  start_shadow;
  logic [7:0]  end_shadow;
  logic [31:0] crc_shadow;

  int unsigned items_queued;
  int unsigned items_accepted;
  int unsigned mismatch_cnt;
  int unsigned cycles;
  bit          in_taken;

  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_style;
  int unsigned stall_phase_left;
  int unsigned stall_tick;

  function automatic logic [31:0] advance_crc(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void predict_frame_bytes(input frame_item_t it);
    logic [7:0]  seq [0:10];
    int          n;
    logic [9:0]  hdr_len;
    logic [31:0] crc_out;
    frame_byte_t fb;
    n = 0;
    hdr_len = (it.len > MaxPayload) ? MaxPayload : it.len;
    if (it.first || it.empty) begin
      if (!it.empty) begin
        crc_shadow = key_shadow ^ CrcInv;
      end
      seq[0] = start_shadow;
      seq[1] = it.msg_type;
      seq[2] = HeaderPad;
      seq[3] = hdr_len[7:0];
      seq[4] = {6'b0, hdr_len[9:8]};
      n = 5;
    end
    if (it.empty) begin
      crc_out = key_shadow;
    end else begin
      seq[n] = it.data;
      n++;
      crc_shadow = advance_crc(crc_shadow, it.data);
      crc_out = crc_shadow ^ CrcInv;
    end
    if (it.last || it.empty) begin
      seq[n]   = crc_out[7:0];
      seq[n+1] = crc_out[15:8];
      seq[n+2] = crc_out[23:16];
      seq[n+3] = crc_out[31:24];
      seq[n+4] = end_shadow;
      n += 5;
      crc_shadow = key_shadow ^ CrcInv;
    end
    for (int i = 0; i < n; i++) begin
      fb.value = seq[i];
      fb.run_end = (i == n - 1);
      frame_bytes_q.push_back(fb);
    end
  endfunction

  task automatic add_item(input logic [7:0] msg_type, input logic [9:0] len,
                          input logic [7:0] data, input logic first, input logic last,
                          input logic empty);
    frame_item_t it;
    it.msg_type = msg_type;
    it.len = len;
    it.data = data;
    it.first = first;
    it.last = last;
    it.empty = empty;
    pending_items_q.push_back(it);
    items_queued++;
  endtask

  task automatic add_frame(input int unsigned n_bytes, input logic [9:0] len);
    logic [7:0] msg_type;
    msg_type = 8'($urandom_range(0, 255));
    for (int unsigned i = 0; i < n_bytes; i++) begin
      add_item(msg_type, len, 8'($urandom_range(0, 255)), i == 0, i == n_bytes - 1, 1'b0);
    end
  endtask

  // Mostly whole frames with random content, with some bare noise items mixed in.
  task automatic random_traffic(input int unsigned count);
    int unsigned start_cnt;
    int unsigned sel;
    int unsigned n_bytes;
    logic [9:0]  len;
    start_cnt = items_queued;
    while (items_queued - start_cnt < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        n_bytes = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        len = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023)) : 10'(n_bytes);
        add_frame(n_bytes, len);
      end else if (sel < 70) begin
        add_item(8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
                 8'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0);
      end else if (sel < 80) begin
        add_item(8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'b1);
      end else if (sel < 88) begin
        add_item(8'($urandom_range(0, 255)), 10'd1, 8'h00, 1'b1, 1'b1, 1'b0);
      end else begin
        add_item(8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    case (idx)
      CfgCrcKey:      key_shadow = value;
      CfgStartMarker: start_shadow = value[7:0];
      CfgEndMarker:   end_shadow = value[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (items_accepted != items_queued || frame_bytes_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Input side: record accepted items and predict the bytes they cause.
  always @(posedge clk_i) begin
    if (rst_ni && item_if.valid && item_if.ready) begin
      predict_frame_bytes({item_if.msg_type, item_if.payload_len, item_if.data_byte,
                           item_if.first_byte, item_if.last_byte, item_if.empty_msg});
      items_accepted++;
      in_taken = 1'b1;
    end
  end

  // Output side: every accepted byte is checked against the oldest expectation.
  always @(posedge clk_i) begin
    frame_byte_t want;
    if (rst_ni && frame_if.valid && frame_if.ready) begin
      if (frame_bytes_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected frame byte %02h run_end %0b", frame_if.out_byte, frame_if.run_end);
        end
      end else begin
        want = frame_bytes_q.pop_front();
        if (frame_if.out_byte !== want.value || frame_if.run_end !== want.run_end) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("frame byte mismatch: expected %02h run_end %0b, got %02h run_end %0b",
                     want.value, want.run_end, frame_if.out_byte, frame_if.run_end);
          end
        end
      end
    end
  end

  // Sender: bursts of items separated by random gaps, some bursts back to back.
  always @(negedge clk_i) begin
    frame_item_t it;
    if (rst_ni && (!item_if.valid || in_taken)) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        item_if.valid <= 1'b0;
      end else if (pending_items_q.size() != 0) begin
        it = pending_items_q.pop_front();
        item_if.msg_type <= it.msg_type;
        item_if.payload_len <= it.len;
        item_if.data_byte <= it.data;
        item_if.first_byte <= it.first;
        item_if.last_byte <= it.last;
        item_if.empty_msg <= it.empty;
        item_if.valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: switches between free flow, light, periodic and heavy stalling.
  always @(negedge clk_i) begin
    stall_tick++;
    if (stall_phase_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_phase_left = $urandom_range(20, 80);
    end else begin
      stall_phase_left--;
    end
    case (stall_style)
      0: frame_if.ready <= 1'b1;
      1: frame_if.ready <= ($urandom_range(0, 3) != 0);
      2: frame_if.ready <= (stall_tick % 4 == 0);
      default: frame_if.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgCrcKey;
    cfg_data_i = 32'h0;
    item_if.valid = 1'b0;
    item_if.msg_type = 8'h0;
    item_if.payload_len = 10'h0;
    item_if.data_byte = 8'h0;
    item_if.first_byte = 1'b0;
    item_if.last_byte = 1'b0;
    item_if.empty_msg = 1'b0;
    frame_if.ready = 1'b0;
    key_shadow = CrcKeyReset;
    start_shadow = StartMarkReset;
    end_shadow = EndMarkReset;
    crc_shadow = CrcKeyReset ^ CrcInv;
    items_queued = 0;
    items_accepted = 0;
    mismatch_cnt = 0;
    cycles = 0;
    in_taken = 1'b0;
    burst_left = 0;
    gap_left = 0;
    stall_style = 0;
    stall_phase_left = 0;
    stall_tick = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with the reset configuration.
    // Payload bytes with no frame start continue from the reset CRC.
    add_item(8'h11, 10'd0, 8'h5A, 1'b0, 1'b0, 1'b0);
    add_item(8'h11, 10'd0, 8'hA5, 1'b0, 1'b1, 1'b0);
    add_item(8'h00, 10'd0, 8'h00, 1'b0, 1'b0, 1'b1);
    // Empty message overrides the other flags; length saturates in the header.
    add_item(8'hFF, 10'd1023, 8'hFF, 1'b1, 1'b1, 1'b1);
    add_item(8'h80, 10'd1, 8'h00, 1'b1, 1'b1, 1'b0);
    add_item(8'h01, 10'd3, 8'h00, 1'b1, 1'b0, 1'b0);
    add_item(8'h01, 10'd3, 8'hFF, 1'b0, 1'b0, 1'b0);
    add_item(8'h01, 10'd3, 8'hA5, 1'b0, 1'b1, 1'b0);
    add_item(8'h22, 10'd512, 8'h3C, 1'b1, 1'b1, 1'b0);
    add_item(8'h33, 10'd513, 8'hC3, 1'b1, 1'b1, 1'b0);
    add_item(8'h44, 10'd255, 8'h01, 1'b1, 1'b1, 1'b0);
    add_item(8'h55, 10'd256, 8'h80, 1'b1, 1'b1, 1'b0);
    add_item(8'h66, 10'd0, 8'hFF, 1'b1, 1'b1, 1'b0);
    // A second frame start in mid-frame restarts the CRC.
    add_item(8'h77, 10'd2, 8'h12, 1'b1, 1'b0, 1'b0);
    add_item(8'h78, 10'd2, 8'h34, 1'b1, 1'b0, 1'b0);
    add_item(8'h78, 10'd2, 8'h56, 1'b0, 1'b1, 1'b0);
    // An empty message in mid-frame resets the CRC as well.
    add_item(8'h99, 10'd4, 8'hAA, 1'b1, 1'b0, 1'b0);
    add_item(8'h9A, 10'd0, 8'h00, 1'b0, 1'b0, 1'b1);
    add_item(8'h9B, 10'd682, 8'h55, 1'b0, 1'b1, 1'b0);
    // Leave a frame open so the key change below lands in mid-frame.
    add_item(8'hC0, 10'd2, 8'h42, 1'b1, 1'b0, 1'b0);
    wait_drained();

    cfg_write(CfgCrcKey, 32'hFFFF_FFFF);
    cfg_write(CfgStartMarker, 32'h0000_0000);
    cfg_write(CfgEndMarker, 32'h0000_00FF);
    add_item(8'hC0, 10'd2, 8'h24, 1'b0, 1'b1, 1'b0);
    add_item(8'hE0, 10'd0, 8'h00, 1'b0, 1'b0, 1'b1);
    random_traffic(40);
    wait_drained();

    cfg_write(CfgCrcKey, $urandom());
    cfg_write(CfgStartMarker, 32'h0000_00FF);
    cfg_write(CfgEndMarker, 32'h0000_0000);
    cfg_write(CfgUnused, $urandom());
    random_traffic(40);
    wait_drained();

    cfg_write(CfgCrcKey, 32'h0000_0000);
    cfg_write(CfgStartMarker, $urandom_range(0, 255));
    cfg_write(CfgEndMarker, $urandom_range(0, 255));
    random_traffic(40);
    wait_drained();

    cfg_write(CfgCrcKey, $urandom());
    cfg_write(CfgStartMarker, {24'h0, StartMarkReset});
    cfg_write(CfgEndMarker, {24'h0, EndMarkReset});
    cfg_write(CfgUnused, $urandom());
    random_traffic(40);
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
